// ----- src/sbrms_pkg.sv -----
// ----------------------------------------------------------------------------
// sbrms_pkg
// Shared widths, constants and controller/datapath interface types for the
// stereo block RMS meter.
// ----------------------------------------------------------------------------
package sbrms_pkg;

  localparam int MAX_FRAMES = 64;

  localparam int WORD_W = 32;
  localparam int SMP_W  = 24;
  localparam int SQ_W   = 2 * SMP_W - 1;
  localparam int SUM_W  = SQ_W + $clog2(MAX_FRAMES);
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);

  localparam int ROOT_W = 24;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int SREM_W = ROOT_W + 2;
  localparam int STEP_W = $clog2(SUM_W);

  localparam int LVL_W  = 24;
  localparam int THR_W  = 10;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(50);

  typedef struct packed {
    logic capture;
    logic square;
    logic accum;
    logic select;
    logic div_step;
    logic sqrt_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic block_end;
    logic div_last;
    logic sqrt_last;
    logic out_free;
  } sts_t;

endpackage

// ----- src/stereo_block_rms_meter_unit.sv -----
// Flow: each transaction is captured and squared, frames are accumulated, and a result is handed
// to the output register; a block-closing frame first runs the divider and square root.
// A new transaction is taken only after the previous result is handed off, so the
// one-bit-per-cycle divider and square root on the louder channel's sum and out_ready_i hold it off.
// Reset: asynchronous, active low; clears sums, count, level, ready flag and failure run, and
// loads the failure threshold with 50.
// ----------------------------------------------------------------------------
// stereo_block_rms_meter_unit
// Stereo block RMS level meter with consecutive read-failure tracking.
// ----------------------------------------------------------------------------
module stereo_block_rms_meter_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [sbrms_pkg::WORD_W-1:0] left_word_i,
  input  logic [sbrms_pkg::WORD_W-1:0] right_word_i,
  input  logic                         last_frame_i,
  input  logic                         cfg_we_i,
  input  logic [sbrms_pkg::THR_W-1:0]  cfg_wdata_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sbrms_pkg::LVL_W-1:0]  level_o,
  output logic                         level_ready_o,
  output logic                         reading_valid_o
);

  sbrms_pkg::cmd_t cmd;
  sbrms_pkg::sts_t sts;

  sbrms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sbrms_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .command_i       (command_i),
    .left_word_i     (left_word_i),
    .right_word_i    (right_word_i),
    .last_frame_i    (last_frame_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .level_o         (level_o),
    .level_ready_o   (level_ready_o),
    .reading_valid_o (reading_valid_o)
  );

endmodule

// ----- src/sbrms_ctrl.sv -----
// ----------------------------------------------------------------------------
// sbrms_ctrl
// Sequencer: capture, square, accumulate, then optional divide and square
// root at block end, then result hand-off.
// ----------------------------------------------------------------------------
module sbrms_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sbrms_pkg::sts_t sts_i,
  output sbrms_pkg::cmd_t cmd_o
);

  localparam int ST_W = 3;

  localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
  localparam logic [ST_W-1:0] ST_SQ   = 3'd1;
  localparam logic [ST_W-1:0] ST_ACC  = 3'd2;
  localparam logic [ST_W-1:0] ST_SEL  = 3'd3;
  localparam logic [ST_W-1:0] ST_DIV  = 3'd4;
  localparam logic [ST_W-1:0] ST_SQRT = 3'd5;
  localparam logic [ST_W-1:0] ST_EMIT = 3'd6;

  logic [ST_W-1:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.square = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.accum = 1'b1;
        state_d     = sts_i.block_end ? ST_SEL : ST_EMIT;
      end
      ST_SEL: begin
        cmd_o.select = 1'b1;
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/sbrms_datapath.sv -----
// ----------------------------------------------------------------------------
// sbrms_datapath
// Square accumulators, bit-serial divider by frame count, bit-serial integer
// square root, failure run tracking and the output register.
// ----------------------------------------------------------------------------
module sbrms_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sbrms_pkg::cmd_t              cmd_i,
  output sbrms_pkg::sts_t              sts_o,
  input  logic                         command_i,
  input  logic [sbrms_pkg::WORD_W-1:0] left_word_i,
  input  logic [sbrms_pkg::WORD_W-1:0] right_word_i,
  input  logic                         last_frame_i,
  input  logic                         cfg_we_i,
  input  logic [sbrms_pkg::THR_W-1:0]  cfg_wdata_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sbrms_pkg::LVL_W-1:0]  level_o,
  output logic                         level_ready_o,
  output logic                         reading_valid_o
);

  // transaction payload
  logic                          cmd_q;
  logic                          last_q;
  logic [sbrms_pkg::SMP_W-1:0]   mag_l_q, mag_r_q;
  logic [sbrms_pkg::SQ_W-1:0]    sq_l_q, sq_r_q;

  // block state
  logic [sbrms_pkg::SUM_W-1:0]   sum_l_q, sum_r_q;
  logic [sbrms_pkg::CNT_W-1:0]   count_q;
  logic [sbrms_pkg::LVL_W-1:0]   latest_q;
  logic                          ready_q;
  logic [sbrms_pkg::THR_W-1:0]   run_q;
  logic [sbrms_pkg::THR_W-1:0]   thr_q;
  logic                          out_valid_q;

  // divide / root working registers
  logic [sbrms_pkg::SUM_W-1:0]   quo_q;
  logic [sbrms_pkg::CNT_W-1:0]   divisor_q;
  logic [sbrms_pkg::CNT_W-1:0]   rem_q;
  logic [sbrms_pkg::SREM_W-1:0]  srem_q;
  logic [sbrms_pkg::ROOT_W-1:0]  root_q;
  logic [sbrms_pkg::STEP_W-1:0]  step_q;

  logic [sbrms_pkg::SMP_W-1:0]   raw_l, raw_r, mag_l, mag_r;
  logic [2*sbrms_pkg::SMP_W-1:0] prod_l, prod_r;
  logic [sbrms_pkg::CNT_W:0]     rem_sh, div_diff;
  logic                          q_bit;
  logic [sbrms_pkg::SREM_W+1:0]  srem_sh, sq_trial, sq_diff;
  logic                          r_bit;
  logic [sbrms_pkg::ROOT_W-1:0]  root_next;

  assign raw_l = left_word_i[sbrms_pkg::WORD_W-1 -: sbrms_pkg::SMP_W];
  assign raw_r = right_word_i[sbrms_pkg::WORD_W-1 -: sbrms_pkg::SMP_W];
  assign mag_l = raw_l[sbrms_pkg::SMP_W-1] ? (sbrms_pkg::SMP_W'(0) - raw_l) : raw_l;
  assign mag_r = raw_r[sbrms_pkg::SMP_W-1] ? (sbrms_pkg::SMP_W'(0) - raw_r) : raw_r;

  assign prod_l = mag_l_q * mag_l_q;
  assign prod_r = mag_r_q * mag_r_q;

  assign rem_sh   = {rem_q, quo_q[sbrms_pkg::SUM_W-1]};
  assign div_diff = rem_sh - {1'b0, divisor_q};
  assign q_bit    = (rem_sh >= {1'b0, divisor_q});

  assign srem_sh   = {srem_q, quo_q[sbrms_pkg::RAD_W-1 -: 2]};
  assign sq_trial  = {2'b00, root_q, 2'b01};
  assign sq_diff   = srem_sh - sq_trial;
  assign r_bit     = (srem_sh >= sq_trial);
  assign root_next = {root_q[sbrms_pkg::ROOT_W-2:0], r_bit};

  assign sts_o.block_end = !cmd_q &&
                           (last_q || (count_q >= sbrms_pkg::CNT_W'(sbrms_pkg::MAX_FRAMES - 1)));
  assign sts_o.div_last  = (step_q == sbrms_pkg::STEP_W'(sbrms_pkg::SUM_W - 1));
  assign sts_o.sqrt_last = (step_q == sbrms_pkg::STEP_W'(sbrms_pkg::ROOT_W - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;

  // state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_l_q     <= '0;
      sum_r_q     <= '0;
      count_q     <= '0;
      latest_q    <= '0;
      ready_q     <= 1'b0;
      run_q       <= '0;
      thr_q       <= sbrms_pkg::THR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_i.accum) begin
        if (cmd_q) begin
          if (run_q < thr_q) begin
            run_q <= run_q + sbrms_pkg::THR_W'(1);
          end
        end else begin
          run_q   <= '0;
          sum_l_q <= sum_l_q + sbrms_pkg::SUM_W'(sq_l_q);
          sum_r_q <= sum_r_q + sbrms_pkg::SUM_W'(sq_r_q);
          count_q <= count_q + sbrms_pkg::CNT_W'(1);
        end
      end
      if (cmd_i.select) begin
        sum_l_q <= '0;
        sum_r_q <= '0;
        count_q <= '0;
      end
      if (cmd_i.sqrt_step && sts_o.sqrt_last) begin
        latest_q <= sbrms_pkg::LVL_W'(root_next);
        ready_q  <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= command_i;
      last_q  <= last_frame_i;
      mag_l_q <= mag_l;
      mag_r_q <= mag_r;
    end
    if (cmd_i.square) begin
      sq_l_q <= prod_l[sbrms_pkg::SQ_W-1:0];
      sq_r_q <= prod_r[sbrms_pkg::SQ_W-1:0];
    end
    if (cmd_i.select) begin
      quo_q     <= (sum_l_q >= sum_r_q) ? sum_l_q : sum_r_q;
      divisor_q <= count_q;
      rem_q     <= '0;
      srem_q    <= '0;
      root_q    <= '0;
      step_q    <= '0;
    end
    if (cmd_i.div_step) begin
      quo_q  <= {quo_q[sbrms_pkg::SUM_W-2:0], q_bit};
      rem_q  <= q_bit ? div_diff[sbrms_pkg::CNT_W-1:0] : rem_sh[sbrms_pkg::CNT_W-1:0];
      step_q <= sts_o.div_last ? '0 : step_q + sbrms_pkg::STEP_W'(1);
    end
    if (cmd_i.sqrt_step) begin
      quo_q  <= {quo_q[sbrms_pkg::SUM_W-3:0], 2'b00};
      srem_q <= r_bit ? sq_diff[sbrms_pkg::SREM_W-1:0] : srem_sh[sbrms_pkg::SREM_W-1:0];
      root_q <= root_next;
      step_q <= step_q + sbrms_pkg::STEP_W'(1);
    end
    if (cmd_i.emit) begin
      level_o         <= latest_q;
      level_ready_o   <= ready_q;
      reading_valid_o <= (run_q < thr_q);
    end
  end

endmodule

// ----- bench/stereo_block_rms_meter_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_block_rms_meter_unit_tb
// Drives stereo frames and read-failure events into the RMS meter under random
// idling on both sides. A scoreboard class predicts each reading and compares
// it field by field. Covered: sample extremes, block close on mark, on frame
// limit and on both, and several failure thresholds including zero and
// lowered-below-run.
// ----------------------------------------------------------------------------
module stereo_block_rms_meter_unit_tb;

  localparam bit CMD_FRAME = 1'b0;
  localparam bit CMD_FAIL  = 1'b1;
  localparam int WORD_W    = sbrms_pkg::WORD_W;
  localparam int LVL_W     = sbrms_pkg::LVL_W;
  localparam int THR_W     = sbrms_pkg::THR_W;

  class rms_scoreboard;
    typedef struct {
      logic [LVL_W-1:0] level;
      logic             level_ready;
      logic             reading_valid;
    } reading_t;

    reading_t          pending_readings[$];
    longint unsigned   left_energy;
    longint unsigned   right_energy;
    int unsigned       frames_in_block;
    logic [LVL_W-1:0]  held_level;
    logic              held_ready;
    int unsigned       fail_run;
    int unsigned       threshold;
    int unsigned       mismatches;
    int unsigned       transactions;
    int unsigned       blocks_closed;
    int unsigned       fail_events;
    int unsigned       threshold_writes;

    function new();
      left_energy      = 0;
      right_energy     = 0;
      frames_in_block  = 0;
      held_level       = '0;
      held_ready       = 1'b0;
      fail_run         = 0;
      threshold        = sbrms_pkg::THR_RESET;
      mismatches       = 0;
      transactions     = 0;
      blocks_closed    = 0;
      fail_events      = 0;
      threshold_writes = 0;
    endfunction

    function void set_threshold(logic [THR_W-1:0] value);
      threshold = value;
      threshold_writes++;
    endfunction

    function longint unsigned sample_square(logic [WORD_W-1:0] word);
      longint s;
      s = longint'($signed(word[WORD_W-1:8]));
      return longint'(s * s);
    endfunction

    function int unsigned floor_root(longint unsigned v);
      logic [24:0] root;
      logic [24:0] trial;
      root = '0;
      for (int b = 24; b >= 0; b--) begin
        trial = root | (25'd1 << b);
        if (longint'(trial) * longint'(trial) <= v) root = trial;
      end
      return root;
    endfunction

    function void note_input(bit cmd, logic [WORD_W-1:0] lw, logic [WORD_W-1:0] rw, bit last);
      reading_t    exp;
      int unsigned lvl_l;
      int unsigned lvl_r;
      transactions++;
      if (cmd == CMD_FAIL) begin
        fail_events++;
        if (fail_run < threshold) fail_run++;
      end else begin
        fail_run = 0;
        left_energy  += sample_square(lw);
        right_energy += sample_square(rw);
        frames_in_block++;
        if (last || frames_in_block >= sbrms_pkg::MAX_FRAMES) begin
          lvl_l = floor_root(left_energy / frames_in_block);
          lvl_r = floor_root(right_energy / frames_in_block);
          held_level      = LVL_W'((lvl_l > lvl_r) ? lvl_l : lvl_r);
          held_ready      = 1'b1;
          left_energy     = 0;
          right_energy    = 0;
          frames_in_block = 0;
          blocks_closed++;
        end
      end
      exp.level         = held_level;
      exp.level_ready   = held_ready;
      exp.reading_valid = (fail_run < threshold);
      pending_readings.push_back(exp);
    endfunction

    function void check_result(logic [LVL_W-1:0] level, logic lr, logic rv);
      reading_t exp;
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected reading level=%0d ready=%b valid=%b", $realtime, level, lr,
                   rv);
        return;
      end
      exp = pending_readings.pop_front();
      if (level !== exp.level || lr !== exp.level_ready || rv !== exp.reading_valid) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: reading mismatch exp level=%0d ready=%b valid=%b %s=%0d ready=%b valid=%b",
                   $realtime, exp.level, exp.level_ready, exp.reading_valid, "got level",
                   level, lr, rv);
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 command_i;
  logic [WORD_W-1:0]    left_word_i;
  logic [WORD_W-1:0]    right_word_i;
  logic                 last_frame_i;
  logic                 cfg_we_i;
  logic [THR_W-1:0]     cfg_wdata_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [LVL_W-1:0]     level_o;
  logic                 level_ready_o;
  logic                 reading_valid_o;

  rms_scoreboard sb;
  int unsigned   in_gap_pct;
  int unsigned   out_stall_pct;
  bit            quiet;

  stereo_block_rms_meter_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .left_word_i     (left_word_i),
    .right_word_i    (right_word_i),
    .last_frame_i    (last_frame_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .level_o         (level_o),
    .level_ready_o   (level_ready_o),
    .reading_valid_o (reading_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("[stereo_block_rms_meter_unit] ERROR");
    $finish;
  end

  // hold off the result side in random bursts
  initial begin
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < out_stall_pct) stall_left = $urandom_range(1, 8);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(level_o, level_ready_o, reading_valid_o);
  end

  task automatic send_item(bit cmd, logic [WORD_W-1:0] lw, logic [WORD_W-1:0] rw, bit last);
    int gap;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 99) < in_gap_pct) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    left_word_i  <= lw;
    right_word_i <= rw;
    last_frame_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(cmd, lw, rw, last);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_readings.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_threshold(value);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 5))
      0: w = {24'h800000, 8'($urandom)};
      1: w = {24'h7FFFFF, 8'($urandom)};
      2: w = {{16{1'($urandom)}}, 16'($urandom)};
      3: w = {{20{1'b0}}, 12'($urandom)} << 8 | 8'($urandom);
      default: w = $urandom;
    endcase
    if ($urandom_range(0, 5) == 2) w = {{17{w[15]}}, w[14:0]};
    return w;
  endfunction

  task automatic run_random(int target);
    int done;
    int len;
    int sel;
    done = 0;
    while (done < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        len = $urandom_range(1, 12);
        repeat (len) send_item(CMD_FAIL, $urandom, $urandom, 1'($urandom));
        done += len;
      end else if (sel < 22) begin
        send_item(CMD_FRAME, pick_word(), pick_word(), 1'b1);
        done++;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 70) len = $urandom_range(1, 16);
        else if (sel < 90) len = $urandom_range(17, 63);
        else len = sbrms_pkg::MAX_FRAMES;
        for (int i = 1; i <= len; i++) begin
          if (i == len && len == sbrms_pkg::MAX_FRAMES)
            send_item(CMD_FRAME, pick_word(), pick_word(), 1'($urandom));
          else
            send_item(CMD_FRAME, pick_word(), pick_word(), i == len);
          if ($urandom_range(0, 19) == 0) begin
            send_item(CMD_FAIL, $urandom, $urandom, 1'($urandom));
            done++;
          end
        end
        done += len;
      end
    end
  endtask

  initial begin
    sb            = new();
    quiet         = 1'b0;
    in_gap_pct    = 30;
    out_stall_pct = 30;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = CMD_FRAME;
    left_word_i   = '0;
    right_word_i  = '0;
    last_frame_i  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes of the samples, padding byte ignored, rounding down
    send_item(CMD_FRAME, 32'h800000FF, 32'h00000000, 1'b1);
    send_item(CMD_FRAME, 32'h7FFFFF00, 32'hFFFFFFFF, 1'b1);
    send_item(CMD_FRAME, 32'h00000100, 32'hFFFFFF00, 1'b0);
    send_item(CMD_FRAME, 32'h00000000, 32'h000000AA, 1'b1);
    // failures ignore payload and keep the open block
    send_item(CMD_FRAME, 32'h12345600, 32'hEDCBA900, 1'b0);
    send_item(CMD_FAIL, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
    send_item(CMD_FAIL, 32'h80000000, 32'h7FFFFFFF, 1'b0);
    send_item(CMD_FRAME, 32'hFFF00000, 32'h00100000, 1'b1);

    write_threshold(THR_W'(1));
    send_item(CMD_FAIL, 32'h0, 32'h0, 1'b0);
    send_item(CMD_FAIL, 32'h0, 32'h0, 1'b0);
    send_item(CMD_FRAME, 32'h00000100, 32'h00000200, 1'b0);

    write_threshold(THR_W'(0));
    send_item(CMD_FRAME, 32'h00000300, 32'h00000400, 1'b1);
    send_item(CMD_FAIL, 32'h0, 32'h0, 1'b0);

    write_threshold(THR_W'(10));
    repeat (6) send_item(CMD_FAIL, 32'h0, 32'h0, 1'b0);
    // lower below the current run
    write_threshold(THR_W'(3));
    send_item(CMD_FAIL, 32'h0, 32'h0, 1'b0);
    send_item(CMD_FRAME, 32'h80000000, 32'h80000000, 1'b1);

    write_threshold(THR_W'(1023));
    in_gap_pct = 40;
    out_stall_pct = 10;
    run_random(75);

    write_threshold(THR_W'(1));
    in_gap_pct = 0;
    out_stall_pct = 50;
    run_random(75);

    write_threshold(THR_W'(0));
    in_gap_pct = 15;
    out_stall_pct = 0;
    run_random(60);

    write_threshold(THR_W'($urandom_range(2, 8)));
    in_gap_pct = 30;
    out_stall_pct = 30;
    run_random(90);

    write_threshold(THR_W'($urandom_range(1, 1023)));
    run_random(75);

    write_threshold(sbrms_pkg::THR_RESET);
    quiet = 1'b1;
    run_random(75);

    wait_drained();
    $display("covered %0d transactions: %0d blocks closed, %0d failure events,",
             sb.transactions, sb.blocks_closed, sb.fail_events);
    $display("%0d threshold writes, mismatches: %0d", sb.threshold_writes, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_readings.size() == 0) begin
      $display("[stereo_block_rms_meter_unit] OK");
    end else begin
      $display("[stereo_block_rms_meter_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/sbrms_pkg.sv
src/sbrms_ctrl.sv
src/sbrms_datapath.sv
src/stereo_block_rms_meter_unit.sv
bench/stereo_block_rms_meter_unit_tb.sv
